@@ sv/am824_stream_format_parser_defines.svh @@
// Assertion macros for the AM824 stream format parser.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef AM824_STREAM_FORMAT_PARSER_DEFINES_SVH
`define AM824_STREAM_FORMAT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AM824_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AM824_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/am824_sfp_pkg.sv @@
// Shared types, constants and lookup functions for the AM824 stream format parser.
// No dependencies.
package am824_sfp_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_SHORT       = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [17:0] rate_hz;
    logic [6:0]  pcm_count;
    logic [3:0]  midi_count;
  } out_word_t;

  // Byte positions within the descriptor header; POS_ENTRIES covers the pair area.
  localparam logic [2:0] POS_ROOT    = 3'd0;
  localparam logic [2:0] POS_LEVEL   = 3'd1;
  localparam logic [2:0] POS_RATE    = 3'd2;
  localparam logic [2:0] POS_SPARE   = 3'd3;
  localparam logic [2:0] POS_COUNT   = 3'd4;
  localparam logic [2:0] POS_ENTRIES = 3'd5;

  localparam logic [7:0] ROOT_BYTE  = 8'h90;
  localparam logic [7:0] LEVEL_BYTE = 8'h40;

  localparam logic [7:0] FMT_PCM_IEC = 8'h00;
  localparam logic [7:0] FMT_PCM_MBLA = 8'h06;
  localparam logic [7:0] FMT_MIDI    = 8'h0d;

  localparam logic [6:0] MAX_PCM_CHANNELS  = 7'd64;
  localparam logic [3:0] MAX_MIDI_CHANNELS = 4'd8;

  localparam logic [2:0] RATE_NONE = 3'd0;

  // Rate code to table index plus one; zero for an unknown code.
  function automatic logic [2:0] rate_index(input logic [7:0] code);
    logic [2:0] idx;
    unique case (code)
      8'h02:   idx = 3'd1;
      8'h03:   idx = 3'd2;
      8'h04:   idx = 3'd3;
      8'h0a:   idx = 3'd4;
      8'h05:   idx = 3'd5;
      8'h07:   idx = 3'd6;
      default: idx = RATE_NONE;
    endcase
    return idx;
  endfunction

  function automatic logic [17:0] rate_value(input logic [2:0] idx);
    logic [17:0] hz;
    unique case (idx)
      3'd1:    hz = 18'd32000;
      3'd2:    hz = 18'd44100;
      3'd3:    hz = 18'd48000;
      3'd4:    hz = 18'd88200;
      3'd5:    hz = 18'd96000;
      3'd6:    hz = 18'd192000;
      default: hz = 18'd0;
    endcase
    return hz;
  endfunction

endpackage

@@ sv/am824_sfp_parser.sv @@
// Descriptor parser: per-byte state update and result formation on the last byte.
// Depends on am824_sfp_pkg and the assertion macros header.
`include "am824_stream_format_parser_defines.svh"

module am824_sfp_parser
  import am824_sfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  item_i,
  output logic      res_vld_o,
  output out_word_t res_o
);

  logic [2:0] hp_q, hp_d;
  logic [7:0] el_q, el_d;
  logic       pp_q, pp_d;
  logic [7:0] held_q, held_d;
  logic [6:0] pcm_q, pcm_d;
  logic [3:0] midi_q, midi_d;
  logic [2:0] ri_q, ri_d;
  status_e    err_q, err_d;

  logic       unsup;
  logic [8:0] pcm_add;
  logic [8:0] midi_add;
  logic       complete;
  status_e    status;

  assign pcm_add  = {2'b00, pcm_q} + {1'b0, held_q};
  assign midi_add = {5'b00000, midi_q} + {1'b0, held_q};

  always_comb begin
    hp_d      = hp_q;
    el_d      = el_q;
    pp_d      = pp_q;
    held_d    = held_q;
    pcm_d     = pcm_q;
    midi_d    = midi_q;
    ri_d      = ri_q;
    err_d     = err_q;
    unsup     = 1'b0;
    complete  = 1'b0;
    status    = ST_OK;
    res_vld_o = 1'b0;
    res_o     = '{status: ST_OK, rate_hz: '0, pcm_count: '0, midi_count: '0};

    if (step_i) begin
      unique case (hp_q)
        POS_ROOT:  unsup = (item_i.data_byte != ROOT_BYTE);
        POS_LEVEL: unsup = (item_i.data_byte != LEVEL_BYTE);
        POS_RATE: begin
          ri_d  = rate_index(item_i.data_byte);
          unsup = (ri_d == RATE_NONE);
        end
        POS_SPARE: ;
        POS_COUNT: begin
          el_d = item_i.data_byte;
          pp_d = 1'b0;
        end
        default: begin
          // pair area; bytes beyond the announced pairs are dropped
          if (el_q != 8'd0) begin
            if (!pp_q) begin
              held_d = item_i.data_byte;
              pp_d   = 1'b1;
            end else begin
              pp_d = 1'b0;
              el_d = el_q - 8'd1;
              if (item_i.data_byte == FMT_PCM_IEC || item_i.data_byte == FMT_PCM_MBLA) begin
                if (pcm_add > {2'b00, MAX_PCM_CHANNELS}) begin
                  unsup = 1'b1;
                  pcm_d = MAX_PCM_CHANNELS;
                end else begin
                  pcm_d = pcm_add[6:0];
                end
              end else if (item_i.data_byte == FMT_MIDI) begin
                if (midi_add > {5'b00000, MAX_MIDI_CHANNELS}) begin
                  unsup  = 1'b1;
                  midi_d = MAX_MIDI_CHANNELS;
                end else begin
                  midi_d = midi_add[3:0];
                end
              end else begin
                unsup = 1'b1;
              end
            end
          end
        end
      endcase

      if (unsup && err_q == ST_OK) begin
        err_d = ST_UNSUPPORTED;
      end
      if (hp_q < POS_ENTRIES) begin
        hp_d = hp_q + 3'd1;
      end

      if (item_i.last_byte) begin
        complete = (hp_d == POS_ENTRIES) && (el_d == 8'd0) && !pp_d;
        priority if (hp_d < POS_SPARE) begin
          status = ST_SHORT;
        end else if (err_d != ST_OK) begin
          status = err_d;
        end else if (!complete) begin
          status = ST_SHORT;
        end else begin
          status = ST_OK;
        end
        res_vld_o        = 1'b1;
        res_o.status     = status;
        res_o.rate_hz    = rate_value(ri_d);
        res_o.pcm_count  = (status == ST_OK) ? pcm_d : 7'd0;
        res_o.midi_count = (status == ST_OK) ? midi_d : 4'd0;
        // start afresh for the next descriptor
        hp_d   = POS_ROOT;
        el_d   = 8'd0;
        pp_d   = 1'b0;
        held_d = 8'd0;
        pcm_d  = 7'd0;
        midi_d = 4'd0;
        ri_d   = RATE_NONE;
        err_d  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q   <= POS_ROOT;
      el_q   <= 8'd0;
      pp_q   <= 1'b0;
      held_q <= 8'd0;
      pcm_q  <= 7'd0;
      midi_q <= 4'd0;
      ri_q   <= RATE_NONE;
      err_q  <= ST_OK;
    end else begin
      hp_q   <= hp_d;
      el_q   <= el_d;
      pp_q   <= pp_d;
      held_q <= held_d;
      pcm_q  <= pcm_d;
      midi_q <= midi_d;
      ri_q   <= ri_d;
      err_q  <= err_d;
    end
  end

  `AM824_ASSERT_NOW(a_hp_range, clk_i, rst_ni, 1'b1, hp_q <= POS_ENTRIES,
    "header position ran past the pair area")
  `AM824_ASSERT_NOW(a_phase_ctx, clk_i, rst_ni, pp_q, (hp_q == POS_ENTRIES) && (el_q != 8'd0),
    "pair phase set outside an open pair")
  `AM824_ASSERT_NOW(a_sum_limit, clk_i, rst_ni, 1'b1,
    (pcm_q <= MAX_PCM_CHANNELS) && (midi_q <= MAX_MIDI_CHANNELS),
    "channel sum exceeds its limit")
  `AM824_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, step_i && item_i.last_byte,
    (hp_q == POS_ROOT) && (err_q == ST_OK) && !pp_q,
    "parser state not cleared after last word")

endmodule

@@ sv/am824_sfp_out_reg.sv @@
// Result register with valid/stall handshake towards the consumer.
// Depends on am824_sfp_pkg.
module am824_sfp_out_reg
  import am824_sfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_word_t res_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic      vld_q, vld_d;
  out_word_t data_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // hold the payload until a new word is loaded
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

@@ sv/am824_stream_format_parser.sv @@
// Top level of the AM824 stream format parser: input register, parser, result register.
// Depends on am824_sfp_pkg, am824_sfp_parser and am824_sfp_out_reg.
//
//   channel  direction  handshake                  word
//   in       consumer   in_valid_i / in_stall_o    in_word_t  (data_byte, last_byte)
//   out      producer   out_valid_o / out_stall_i  out_word_t (status, rate_hz, counts)
//
// One descriptor byte per cycle unless in_stall_o is high; results are registered.
// Latency is set by the input register and the result register around the parser step.
// Reset clears all parser state and both valid flags; no clearing pass is needed.
// The input side stalls only when a last byte is waiting and the result register is
// still held by a stalled consumer; other bytes keep flowing while a result waits.
module am824_stream_format_parser
  import am824_sfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic      in_vld_q, in_vld_d;
  in_word_t  in_q;
  logic      step;
  logic      res_vld;
  out_word_t res;

  // advance the held word unless it is a last byte facing a full, stalled result register
  assign step       = in_vld_q && (!in_q.last_byte || !out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  am824_sfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  am824_sfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_vld),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for am824_stream_format_parser: descriptors in, one status word out.
// Depends on am824_sfp_pkg for the word types, status codes and descriptor constants.
// A scoreboard class predicts each result from the accepted bytes and checks the output words.
module tb;
  import am824_sfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_BYTES = 1800;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 12;

  localparam logic [7:0]  UNKNOWN_RATE_CODE = 8'h01;
  localparam logic [7:0]  RATE_CODE_TBL [6] = '{8'h02, 8'h03, 8'h04, 8'h0a, 8'h05, 8'h07};
  localparam logic [17:0] RATE_HZ_TBL [6]   = '{18'd32000, 18'd44100, 18'd48000,
                                                18'd88200, 18'd96000, 18'd192000};

  class descriptor_scoreboard;
    logic [2:0]  hdr_pos;
    logic [7:0]  pairs_left;
    bit          want_format;
    logic [7:0]  chan_byte;
    logic [6:0]  pcm_total;
    logic [3:0]  midi_total;
    logic [2:0]  rate_slot;
    status_e     err_code;
    out_word_t   pending[$];
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      hdr_pos     = POS_ROOT;
      pairs_left  = '0;
      want_format = 1'b0;
      chan_byte   = '0;
      pcm_total   = '0;
      midi_total  = '0;
      rate_slot   = '0;
      err_code    = ST_OK;
    endfunction

    // Keep only the first error of a descriptor.
    function void flag_error(status_e code);
      if (err_code == ST_OK) err_code = code;
    endfunction

    function void note_byte(in_word_t w);
      int unsigned total;
      int          i;
      bit          complete;
      out_word_t   r;
      case (hdr_pos)
        POS_ROOT:  if (w.data_byte != ROOT_BYTE) flag_error(ST_UNSUPPORTED);
        POS_LEVEL: if (w.data_byte != LEVEL_BYTE) flag_error(ST_UNSUPPORTED);
        POS_RATE: begin
          rate_slot = '0;
          for (i = 0; i < 6; i++)
            if (w.data_byte == RATE_CODE_TBL[i]) rate_slot = 3'(i + 1);
          if (rate_slot == '0) flag_error(ST_UNSUPPORTED);
        end
        POS_SPARE: ;
        POS_COUNT: begin
          pairs_left  = w.data_byte;
          want_format = 1'b0;
        end
        default: begin
          // Drop trailing bytes once every announced pair is in.
          if (pairs_left != 0) begin
            if (!want_format) begin
              chan_byte   = w.data_byte;
              want_format = 1'b1;
            end else begin
              if (w.data_byte == FMT_PCM_IEC || w.data_byte == FMT_PCM_MBLA) begin
                total = pcm_total + chan_byte;
                if (total > MAX_PCM_CHANNELS) begin
                  flag_error(ST_UNSUPPORTED);
                  total = MAX_PCM_CHANNELS;
                end
                pcm_total = 7'(total);
              end else if (w.data_byte == FMT_MIDI) begin
                total = midi_total + chan_byte;
                if (total > MAX_MIDI_CHANNELS) begin
                  flag_error(ST_UNSUPPORTED);
                  total = MAX_MIDI_CHANNELS;
                end
                midi_total = 4'(total);
              end else begin
                flag_error(ST_UNSUPPORTED);
              end
              want_format = 1'b0;
              pairs_left  = pairs_left - 8'd1;
            end
          end
        end
      endcase
      if (hdr_pos < POS_ENTRIES) hdr_pos = hdr_pos + 3'd1;

      if (w.last_byte) begin
        complete  = hdr_pos >= POS_ENTRIES && pairs_left == 0 && !want_format;
        r.rate_hz = (rate_slot != '0) ? RATE_HZ_TBL[rate_slot - 3'd1] : '0;
        if (hdr_pos < POS_SPARE)    r.status = ST_SHORT;
        else if (err_code != ST_OK) r.status = err_code;
        else if (!complete)         r.status = ST_SHORT;
        else                        r.status = ST_OK;
        r.pcm_count  = (r.status == ST_OK) ? pcm_total : '0;
        r.midi_count = (r.status == ST_OK) ? midi_total : '0;
        pending.push_back(r);
        clear();
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: status %0d rate_hz %0d",
               got.status, got.rate_hz);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.rate_hz !== want.rate_hz) begin
        $error("rate_hz: expected %0d, got %0d", want.rate_hz, got.rate_hz);
        mismatches++;
      end
      if (got.pcm_count !== want.pcm_count) begin
        $error("pcm_count: expected %0d, got %0d", want.pcm_count, got.pcm_count);
        mismatches++;
      end
      if (got.midi_count !== want.midi_count) begin
        $error("midi_count: expected %0d, got %0d", want.midi_count, got.midi_count);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  descriptor_scoreboard sb = new();

  logic [7:0]  desc_bytes[$];
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          sender_calm;

  am824_stream_format_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = draw_gap(sender_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_descriptor();
    int i;
    sender_calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < desc_bytes.size(); i++)
      send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
    bytes_sent += desc_bytes.size();
  endtask

  function automatic logic [7:0] draw_format();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return FMT_PCM_IEC;
    if (pick < 6) return FMT_PCM_MBLA;
    if (pick < 9) return FMT_MIDI;
    return 8'($urandom);
  endfunction

  // Mostly well-formed descriptors; some cut short, some with a wild count, some noise.
  task automatic build_random_descriptor();
    int unsigned kind;
    int unsigned npairs;
    int unsigned count;
    int unsigned cut;
    int unsigned i;
    desc_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) desc_bytes.push_back(8'($urandom));
      return;
    end
    desc_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : ROOT_BYTE);
    desc_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : LEVEL_BYTE);
    desc_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                      : RATE_CODE_TBL[$urandom_range(0, 5)]);
    desc_bytes.push_back(8'($urandom));
    npairs = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    count  = npairs;
    if (kind == 8) begin
      count  = $urandom_range(0, 255);
      npairs = (count < 6) ? count : $urandom_range(0, 6);
    end
    desc_bytes.push_back(8'(count));
    for (i = 0; i < npairs; i++) begin
      desc_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 24)));
      desc_bytes.push_back(draw_format());
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) desc_bytes.push_back(8'($urandom));
    if (kind == 7) begin
      cut = $urandom_range(1, desc_bytes.size());
      while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
    end
  endtask

  // Result side: random stalls, calm stretches, and two long hold-offs that back up the input.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          calm;
    out_stall_i = 1'b0;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = (taken == 30 || taken == 150) ? HOLD_CYCLES : draw_gap(calm);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    bytes_sent  = 0;
    sender_calm = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single byte, and two bytes with a bad root: both too short
    desc_bytes = '{ROOT_BYTE};
    send_descriptor();
    desc_bytes = '{8'h00, LEVEL_BYTE};
    send_descriptor();
    // unknown rate code
    desc_bytes = '{ROOT_BYTE, LEVEL_BYTE, UNKNOWN_RATE_CODE};
    send_descriptor();
    // ends before the entry count
    desc_bytes = '{ROOT_BYTE, LEVEL_BYTE, RATE_CODE_TBL[5], 8'hFF};
    send_descriptor();
    // good descriptor with a trailing byte
    desc_bytes = '{ROOT_BYTE, LEVEL_BYTE, RATE_CODE_TBL[1], 8'h00, 8'h02,
                   8'h05, FMT_PCM_MBLA, 8'h02, FMT_MIDI, 8'hFF};
    send_descriptor();
    // PCM sum over its limit
    desc_bytes = '{ROOT_BYTE, LEVEL_BYTE, RATE_CODE_TBL[3], 8'h00, 8'h01,
                   8'hFF, FMT_PCM_IEC};
    send_descriptor();

    while (bytes_sent < RANDOM_BYTES) begin
      build_random_descriptor();
      send_descriptor();
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
